@@ hw/rtl/adagrad_parameter_update_assert.svh @@
// ----------------------------------------------------------------------------
// AdaGrad update assertion macros
// Shorthand for the concurrent checks in the parameter update top level.
// ----------------------------------------------------------------------------
`ifndef ADAGRAD_PARAMETER_UPDATE_ASSERT_SVH
`define ADAGRAD_PARAMETER_UPDATE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define AGU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define AGU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/agu_pkg.sv @@
// ----------------------------------------------------------------------------
// AdaGrad update package
// Widths, stage numbers, constants and the pipeline stage record.
// ----------------------------------------------------------------------------
`default_nettype none

package agu_pkg;

   localparam int unsigned VEC_LEN   = 1024;
   localparam int unsigned ADDR_W    = $clog2(VEC_LEN);
   localparam int unsigned IDX_W     = 10;

   localparam logic [63:0] SUM_INIT  = 64'd42950;
   localparam logic [31:0] STEP_INIT = 32'd655;
   localparam logic [32:0] DELTA_MAX = 33'h1_0000_0000;

   // Stage numbers along the pipeline.
   localparam int unsigned ST_SUM    = 2;
   localparam int unsigned SQRT_N    = 32;
   localparam int unsigned ST_ROOT   = ST_SUM + SQRT_N;
   localparam int unsigned ST_DSETUP = ST_ROOT + 1;
   localparam int unsigned DIV_N     = 33;
   localparam int unsigned ST_DLAST  = ST_DSETUP + DIV_N;
   localparam int unsigned ST_DELTA  = ST_DLAST + 1;
   localparam int unsigned ST_OUT    = ST_DELTA + 1;

   typedef enum logic {
      KIND_LOAD   = 1'b0,
      KIND_UPDATE = 1'b1
   } kind_type;

   // One request as it travels down the pipeline.
   typedef struct packed {
      logic               v;
      kind_type           kind;
      logic [IDX_W-1:0]   idx;
      logic signed [31:0] w;
      logic signed [31:0] g;
      logic               last;
      logic [31:0]        mag;
      logic [63:0]        sq;
      logic [63:0]        prod;
      logic [63:0]        sum;
      logic [31:0]        pg;
      logic [31:0]        chg;
      logic [63:0]        vr;
      logic [63:0]        res;
      logic [31:0]        r;
      logic               ovf;
      logic [63:0]        rem;
      logic [32:0]        q;
      logic [32:0]        delta;
   } stage_type;

endpackage

`default_nettype wire

@@ hw/rtl/adagrad_parameter_update.sv @@
// ----------------------------------------------------------------------------
// AdaGrad parameter update
// Streams load and gradient requests through a deep pipeline holding per
// element weights, squared-gradient sums and previous gradients.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                         Direction   Handshake
//   request   req_*                         in          req_valid / req_ready
//   result    rsp_*                         out         rsp_valid / rsp_ready
//   config    csr_write_enable, _data       in          write enable only
//
// One request enters per cycle unless a stalled result or the clearing pass holds
// it off. The 32 square-root stages and 33 divider stages make up most of the pipeline.
// After reset the sum and gradient store is cleared, one entry a cycle; no
// request is taken during that pass.
// A stalled result freezes the whole pipeline; same-index requests are
// handled by forwarding, so they never stall.
//
`default_nettype none

module adagrad_parameter_update (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_kind,
   input  wire logic [agu_pkg::IDX_W-1:0] req_elem_index,
   input  wire logic signed [31:0]        req_weight_in,
   input  wire logic signed [31:0]        req_grad_value,
   input  wire logic                      req_last_in,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [agu_pkg::IDX_W-1:0]      rsp_elem_index_out,
   output logic signed [31:0]             rsp_weight_out,
   output logic [31:0]                    rsp_grad_change,
   output logic                           rsp_last_out,
   input  wire logic                      csr_write_enable,
   input  wire logic [31:0]               csr_write_data
);

   agu_pkg::stage_type stg_ff [0:agu_pkg::ST_OUT];
   agu_pkg::stage_type stg_in [0:agu_pkg::ST_OUT];

   logic [31:0]                 step_ff;
   logic                        clr_busy_ff;
   logic [agu_pkg::ADDR_W-1:0]  clr_cnt_ff;
   logic                        adv;

   logic [95:0]                 st_mem [0:agu_pkg::VEC_LEN-1];
   logic [95:0]                 st_rd_ff;
   logic [95:0]                 st_fwd;
   logic                        st_we;
   logic [agu_pkg::ADDR_W-1:0]  st_wa;
   logic [95:0]                 st_wd;
   logic [agu_pkg::ADDR_W-1:0]  st_ra;

   logic [31:0]                 wt_mem [0:agu_pkg::VEC_LEN-1];
   logic [31:0]                 wt_rd_ff;
   logic signed [31:0]          wt_fwd;
   logic [agu_pkg::ADDR_W-1:0]  wt_ra;

   // The whole pipeline moves when the output register is free or drained.
   assign adv       = !stg_ff[agu_pkg::ST_OUT].v || rsp_ready;
   assign req_ready = adv && !clr_busy_ff;

   // Step size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= agu_pkg::STEP_INIT;
      end else if (csr_write_enable) begin
         step_ff <= csr_write_data;
      end
   end

   // Clearing pass over the sum and gradient store after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == '1) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Input stage captures the request and its gradient magnitude.
   always_comb begin
      stg_in[0]      = stg_ff[0];
      stg_in[0].v    = req_valid && req_ready;
      stg_in[0].kind = agu_pkg::kind_type'(req_kind);
      stg_in[0].idx  = req_elem_index;
      stg_in[0].w    = req_weight_in;
      stg_in[0].g    = req_grad_value;
      stg_in[0].last = req_last_in;
      stg_in[0].mag  = req_grad_value[31] ? 32'(-req_grad_value) : 32'(req_grad_value);
   end

   // Sum and previous gradient store: read for the request entering stage 1,
   // written when stage 1 moves on.
   assign st_ra = adv ? agu_pkg::ADDR_W'(stg_ff[0].idx) : agu_pkg::ADDR_W'(stg_ff[1].idx);

   always_comb begin
      if (clr_busy_ff) begin
         st_we = 1'b1;
         st_wa = clr_cnt_ff;
         st_wd = {agu_pkg::SUM_INIT, 32'd0};
      end else begin
         st_we = adv && stg_ff[1].v;
         st_wa = agu_pkg::ADDR_W'(stg_ff[1].idx);
         st_wd = {stg_in[agu_pkg::ST_SUM].sum, stg_in[agu_pkg::ST_SUM].pg};
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_wa] <= st_wd;
      end
      st_rd_ff <= st_mem[st_ra];
   end

   // The request one stage ahead wrote the same entry at the read edge.
   assign st_fwd = (stg_ff[2].v && stg_ff[2].idx == stg_ff[1].idx)
                   ? {stg_ff[2].sum, stg_ff[2].pg} : st_rd_ff;

   // Weight store: read for the request entering the delta stage, written
   // when it moves into the output register.
   assign wt_ra = adv ? agu_pkg::ADDR_W'(stg_ff[agu_pkg::ST_DLAST].idx)
                      : agu_pkg::ADDR_W'(stg_ff[agu_pkg::ST_DELTA].idx);

   always_ff @(posedge clock) begin
      if (adv && stg_ff[agu_pkg::ST_DELTA].v) begin
         wt_mem[agu_pkg::ADDR_W'(stg_ff[agu_pkg::ST_DELTA].idx)] <= stg_in[agu_pkg::ST_OUT].w;
      end
      wt_rd_ff <= wt_mem[wt_ra];
   end

   assign wt_fwd = (stg_ff[agu_pkg::ST_OUT].v &&
                    stg_ff[agu_pkg::ST_OUT].idx == stg_ff[agu_pkg::ST_DELTA].idx)
                   ? stg_ff[agu_pkg::ST_OUT].w : $signed(wt_rd_ff);

   // Per-stage work.
   for (genvar s = 1; s <= agu_pkg::ST_OUT; s++) begin : g_stage
      if (s == 1) begin : g_mul
         // Gradient squared and step times magnitude.
         always_comb begin
            stg_in[s]      = stg_ff[s-1];
            stg_in[s].sq   = 64'(stg_ff[s-1].mag) * 64'(stg_ff[s-1].mag);
            stg_in[s].prod = 64'(step_ff) * 64'(stg_ff[s-1].mag);
         end
      end else if (s == agu_pkg::ST_SUM) begin : g_sum
         // Saturating sum update and gradient change; a load resets the sum and previous gradient.
         always_comb begin
            logic [64:0]        s65;
            logic signed [32:0] df;
            stg_in[s] = stg_ff[s-1];
            s65 = {1'b0, st_fwd[95:32]} + {1'b0, stg_ff[s-1].sq};
            df  = 33'($signed(st_fwd[31:0])) - 33'(stg_ff[s-1].g);
            if (stg_ff[s-1].kind == agu_pkg::KIND_UPDATE) begin
               stg_in[s].sum = s65[64] ? '1 : s65[63:0];
               stg_in[s].pg  = stg_ff[s-1].g;
               stg_in[s].chg = df[32] ? 32'(-df) : 32'(df);
            end else begin
               stg_in[s].sum = agu_pkg::SUM_INIT;
               stg_in[s].pg  = '0;
               stg_in[s].chg = '0;
            end
            stg_in[s].vr  = stg_in[s].sum;
            stg_in[s].res = '0;
         end
      end else if (s <= agu_pkg::ST_ROOT) begin : g_sqrt
         // One digit of the integer square root per stage.
         localparam int unsigned K = s - agu_pkg::ST_SUM - 1;
         always_comb begin
            logic [63:0] bt;
            logic [63:0] t;
            stg_in[s] = stg_ff[s-1];
            bt = 64'd1 << (62 - 2 * K);
            t  = stg_ff[s-1].res + bt;
            if (stg_ff[s-1].vr >= t) begin
               stg_in[s].vr  = stg_ff[s-1].vr - t;
               stg_in[s].res = (stg_ff[s-1].res >> 1) + bt;
            end else begin
               stg_in[s].res = stg_ff[s-1].res >> 1;
            end
         end
      end else if (s == agu_pkg::ST_DSETUP) begin : g_dsetup
         // Divider setup: a quotient of 2^33 or more is clamped anyway.
         always_comb begin
            logic [31:0] rt;
            stg_in[s] = stg_ff[s-1];
            rt = (stg_ff[s-1].res[31:0] == '0) ? 32'd1 : stg_ff[s-1].res[31:0];
            stg_in[s].r   = rt;
            stg_in[s].ovf = {1'b0, stg_ff[s-1].prod} >= {rt, 33'd0};
            stg_in[s].rem = stg_ff[s-1].prod;
            stg_in[s].q   = '0;
         end
      end else if (s <= agu_pkg::ST_DLAST) begin : g_div
         // One quotient bit per stage, most significant first.
         localparam int unsigned I = agu_pkg::ST_DLAST - s;
         always_comb begin
            logic [65:0] dv;
            stg_in[s] = stg_ff[s-1];
            dv = 66'(stg_ff[s-1].r) << I;
            if ({2'b0, stg_ff[s-1].rem} >= dv) begin
               stg_in[s].rem  = stg_ff[s-1].rem - dv[63:0];
               stg_in[s].q[I] = 1'b1;
            end
         end
      end else if (s == agu_pkg::ST_DELTA) begin : g_delta
         // Clamp the weight step.
         always_comb begin
            stg_in[s] = stg_ff[s-1];
            stg_in[s].delta = (stg_ff[s-1].ovf || stg_ff[s-1].q > agu_pkg::DELTA_MAX)
                              ? agu_pkg::DELTA_MAX : stg_ff[s-1].q;
         end
      end else begin : g_wout
         // Apply the step to the stored weight with saturation; a load keeps its own weight.
         always_comb begin
            logic signed [34:0] ws;
            logic signed [34:0] dl;
            logic signed [34:0] nw;
            stg_in[s] = stg_ff[s-1];
            ws = 35'(wt_fwd);
            dl = $signed({2'b0, stg_ff[s-1].delta});
            nw = stg_ff[s-1].g[31] ? ws + dl : ws - dl;
            if (stg_ff[s-1].kind == agu_pkg::KIND_UPDATE) begin
               if (nw > 35'sd2147483647) begin
                  stg_in[s].w = 32'sh7FFF_FFFF;
               end else if (nw < -35'sd2147483648) begin
                  stg_in[s].w = 32'sh8000_0000;
               end else begin
                  stg_in[s].w = nw[31:0];
               end
            end
         end
      end
   end

   // Pipeline registers; only the valid bits are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= agu_pkg::ST_OUT; i++) begin
            stg_ff[i].v <= 1'b0;
         end
      end else if (adv) begin
         for (int i = 0; i <= agu_pkg::ST_OUT; i++) begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

   // Result ports.
   assign rsp_valid          = stg_ff[agu_pkg::ST_OUT].v;
   assign rsp_elem_index_out = stg_ff[agu_pkg::ST_OUT].idx;
   assign rsp_weight_out     = stg_ff[agu_pkg::ST_OUT].w;
   assign rsp_grad_change    = stg_ff[agu_pkg::ST_OUT].chg;
   assign rsp_last_out       = stg_ff[agu_pkg::ST_OUT].last;

   // Checks.
`include "adagrad_parameter_update_assert.svh"

   `AGU_ASSERT_NOW(a_no_req_in_clear, clr_busy_ff, !req_ready, "request taken during clear")
   `AGU_ASSERT_NEXT(a_clear_ends, clr_busy_ff && clr_cnt_ff == '1, !clr_busy_ff, "clear pass overran")
   `AGU_ASSERT_NOW(a_load_no_change,
      rsp_valid && stg_ff[agu_pkg::ST_OUT].kind == agu_pkg::KIND_LOAD,
      rsp_grad_change == '0, "load result with nonzero gradient change")
   `AGU_ASSERT_NEXT(a_stall_holds, rsp_valid && !rsp_ready,
      rsp_valid && $stable(stg_ff[agu_pkg::ST_DELTA].v), "pipeline moved during stall")

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// AdaGrad parameter update testbench
// Drives load and gradient requests into the update pipeline, predicts each
// result from a private copy of the per-element state and checks every field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

   localparam int unsigned LATENCY   = 71;
   localparam longint      CYCLE_MAX = 400000;

   typedef struct packed {
      logic [agu_pkg::IDX_W-1:0] idx;
      logic signed [31:0]        weight;
      logic [31:0]               change;
      logic                      last;
   } update_result_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_kind;
   logic [agu_pkg::IDX_W-1:0] req_elem_index;
   logic signed [31:0] req_weight_in;
   logic signed [31:0] req_grad_value;
   logic req_last_in;
   logic rsp_valid;
   logic rsp_ready;
   logic [agu_pkg::IDX_W-1:0] rsp_elem_index_out;
   logic signed [31:0] rsp_weight_out;
   logic [31:0] rsp_grad_change;
   logic rsp_last_out;
   logic csr_write_enable;
   logic [31:0] csr_write_data;

   // Predictor state.
   logic [31:0] model_step;
   logic [31:0] model_weight [agu_pkg::VEC_LEN];
   logic [63:0] model_sum [agu_pkg::VEC_LEN];
   logic [31:0] model_prev_grad [agu_pkg::VEC_LEN];
   bit          loaded [agu_pkg::VEC_LEN];

   update_result_type pending_results[$];
   int  mismatch_count;
   int  result_count;
   int  update_count;
   longint cycle_count;
   int  hold_off_cycles;
   bit  stall_random;

   adagrad_parameter_update dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_elem_index     (req_elem_index),
      .req_weight_in      (req_weight_in),
      .req_grad_value     (req_grad_value),
      .req_last_in        (req_last_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_elem_index_out (rsp_elem_index_out),
      .rsp_weight_out     (rsp_weight_out),
      .rsp_grad_change    (rsp_grad_change),
      .rsp_last_out       (rsp_last_out),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Integer square root, floor.
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bit_pos;
      res = 64'd0;
      bit_pos = 64'd1 << 62;
      while (bit_pos > v) bit_pos = bit_pos >> 2;
      while (bit_pos != 0) begin
         if (v >= res + bit_pos) begin
            v = v - (res + bit_pos);
            res = (res >> 1) + bit_pos;
         end else begin
            res = res >> 1;
         end
         bit_pos = bit_pos >> 2;
      end
      return res;
   endfunction

   // Apply one request to the predicted state and return the expected result.
   function automatic update_result_type adagrad_predict(
      input agu_pkg::kind_type kind, input logic [agu_pkg::IDX_W-1:0] idx,
      input logic signed [31:0] w_in, input logic signed [31:0] g,
      input logic last);
      update_result_type rr;
      logic [31:0]  mag;
      logic [63:0]  sq;
      logic [63:0]  sum;
      logic [63:0]  root;
      logic [63:0]  delta;
      longint       w;
      longint       diff;
      int unsigned  e;
      e = idx % agu_pkg::VEC_LEN;
      rr.change = 32'd0;
      if (kind == agu_pkg::KIND_LOAD) begin
         model_weight[e] = w_in;
         model_prev_grad[e] = 32'd0;
         model_sum[e] = agu_pkg::SUM_INIT;
      end else begin
         mag = (g < 0) ? 32'(-longint'(g)) : 32'(g);
         sq = 64'(mag) * 64'(mag);
         sum = model_sum[e];
         sum = (sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : sum + sq;
         model_sum[e] = sum;
         root = isqrt64(sum);
         if (root == 0) root = 1;
         delta = (64'(model_step) * 64'(mag)) / root;
         if (delta > 64'h1_0000_0000) delta = 64'h1_0000_0000;
         w = longint'($signed(model_weight[e]));
         if (g < 0) w = w + longint'(delta);
         else w = w - longint'(delta);
         if (w > 64'sd2147483647) w = 64'sd2147483647;
         if (w < -64'sd2147483648) w = -64'sd2147483648;
         model_weight[e] = 32'(w);
         diff = longint'($signed(model_prev_grad[e])) - longint'(g);
         rr.change = 32'((diff < 0) ? -diff : diff);
         model_prev_grad[e] = g;
      end
      rr.idx = idx;
      rr.weight = model_weight[e];
      rr.last = last;
      return rr;
   endfunction

   // Send one request, predict it at acceptance, then leave a random gap unless no_gap is set.
   task automatic send_request(input agu_pkg::kind_type kind,
                               input logic [agu_pkg::IDX_W-1:0] idx,
                               input logic signed [31:0] w_in,
                               input logic signed [31:0] g, input logic last,
                               input bit no_gap = 0);
      int gap;
      update_result_type expected;
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_elem_index <= idx;
      req_weight_in  <= w_in;
      req_grad_value <= g;
      req_last_in    <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected = adagrad_predict(kind, idx, w_in, g, last);
      pending_results = {pending_results, expected};
      if (kind == agu_pkg::KIND_LOAD) loaded[idx % agu_pkg::VEC_LEN] = 1'b1;
      else update_count++;
      gap = no_gap ? 0 : (($urandom_range(0, 9) < 6) ? 0 :
            (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3)));
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every expected result is back, then let the pipeline drain.
   task automatic drain();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_step(input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_step = value;
   endtask

   function automatic logic signed [31:0] random_grad();
      case ($urandom_range(0, 5))
         0: return $signed($urandom());
         1: return $signed(32'($urandom_range(0, 32'h0003_0000))) - 32'sh0001_8000;
         2: return 32'sh7FFF_FFFF;
         3: return 32'sh8000_0000;
         default: return $signed(32'($urandom_range(0, 32'h0000_4000))) - 32'sh2000;
      endcase
   endfunction

   function automatic logic [agu_pkg::IDX_W-1:0] random_loaded_index();
      logic [agu_pkg::IDX_W-1:0] i;
      do i = agu_pkg::IDX_W'($urandom()); while (!loaded[i]);
      return i;
   endfunction

   // Extremes of weight and gradient, both kinds, and repeat hits on the same index.
   task automatic test_directed();
      send_request(agu_pkg::KIND_LOAD, 10'd0, 32'sh7FFF_FFFF, 32'sh1234_5678, 1'b0);
      send_request(agu_pkg::KIND_UPDATE, 10'd0, 32'sh0BAD_0BAD, 32'sh8000_0000, 1'b1);
      send_request(agu_pkg::KIND_UPDATE, 10'd0, 32'sh0, 32'sh7FFF_FFFF, 1'b0, 1);
      send_request(agu_pkg::KIND_UPDATE, 10'd0, 32'sh0, 32'sh8000_0000, 1'b0, 1);
      send_request(agu_pkg::KIND_LOAD, 10'd1023, 32'sh8000_0000, 32'sh0, 1'b1);
      send_request(agu_pkg::KIND_UPDATE, 10'd1023, 32'sh0, 32'sh7FFF_FFFF, 1'b0, 1);
      send_request(agu_pkg::KIND_UPDATE, 10'd1023, 32'sh0, 32'sh0, 1'b1, 1);
      send_request(agu_pkg::KIND_LOAD, 10'd512, 32'sh0, 32'sh0, 1'b0);
      send_request(agu_pkg::KIND_UPDATE, 10'd512, 32'sh0, 32'sh0001_0000, 1'b0, 1);
      send_request(agu_pkg::KIND_UPDATE, 10'd512, 32'sh0, -32'sh0001_0000, 1'b0, 1);
      send_request(agu_pkg::KIND_UPDATE, 10'd512, 32'sh0, 32'sh0, 1'b1, 1);
      send_request(agu_pkg::KIND_LOAD, 10'd512, 32'sh0001_0000, 32'sh7FFF_FFFF, 1'b0, 1);
      send_request(agu_pkg::KIND_UPDATE, 10'd512, 32'shFFFF_FFFF, 32'sh0000_0001, 1'b1);
      send_request(agu_pkg::KIND_LOAD, 10'd341, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b1);
      send_request(agu_pkg::KIND_UPDATE, 10'd341, 32'shAAAA_AAAA, 32'sh5555_5555, 1'b0);
      go_idle();
      drain();
   endtask

   // Learning rate at both extremes; the largest drives the weight into saturation.
   task automatic test_step_extremes();
      int k;
      write_step(32'hFFFF_FFFF);
      send_request(agu_pkg::KIND_LOAD, 10'd7, 32'sh7FFF_0000, 32'sh0, 1'b0);
      for (k = 0; k < 4; k++)
         send_request(agu_pkg::KIND_UPDATE, 10'd7, 32'sh0, -32'sh0000_0100, 1'b0);
      send_request(agu_pkg::KIND_LOAD, 10'd8, 32'sh8000_1000, 32'sh0, 1'b0);
      for (k = 0; k < 4; k++)
         send_request(agu_pkg::KIND_UPDATE, 10'd8, 32'sh0, 32'sh7FFF_FFFF, 1'b1);
      go_idle();
      drain();
      write_step(32'd0);
      send_request(agu_pkg::KIND_UPDATE, 10'd7, 32'sh0, 32'sh0100_0000, 1'b0);
      send_request(agu_pkg::KIND_UPDATE, 10'd8, 32'sh0, -32'sh0100_0000, 1'b1);
      go_idle();
      drain();
   endtask

   // Random vectors: mostly updates to loaded elements, with reloads mixed in.
   task automatic test_random(input int count, input logic [31:0] step);
      int k;
      int base;
      int span;
      write_step(step);
      k = 0;
      while (k < count) begin
         base = $urandom_range(0, agu_pkg::VEC_LEN - 1);
         span = $urandom_range(1, 16);
         for (int j = 0; j < span && k < count; j++, k++) begin
            logic [agu_pkg::IDX_W-1:0] i;
            i = agu_pkg::IDX_W'(base + j);
            if (!loaded[i] || $urandom_range(0, 9) == 0)
               send_request(agu_pkg::KIND_LOAD, i, $signed($urandom()), random_grad(),
                            1'($urandom()));
            else if ($urandom_range(0, 3) == 0)
               send_request(agu_pkg::KIND_UPDATE, random_loaded_index(),
                            $signed($urandom()), random_grad(), 1'($urandom()));
            else
               send_request(agu_pkg::KIND_UPDATE, i, $signed($urandom()), random_grad(),
                            j == span - 1);
         end
      end
      go_idle();
      drain();
   endtask

   // Long result stall while requests keep coming, so the pipeline backs up.
   task automatic test_backpressure();
      int k;
      hold_off_cycles = 300;
      for (k = 0; k < 200; k++)
         send_request(agu_pkg::KIND_UPDATE, random_loaded_index(), 32'sh0, random_grad(),
                      1'b0, 1);
      go_idle();
      drain();
   endtask

   // Result side: random stalls, or a counted hold-off when one is requested.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_off_cycles--;
         end else if (!stall_random || $urandom_range(0, 9) < 7) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat (($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : 0)
               @(posedge clock);
         end
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      update_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: index %0d weight %h", rsp_elem_index_out,
                        rsp_weight_out);
         end else begin
            want = pending_results.pop_front();
            if (rsp_elem_index_out !== want.idx || rsp_weight_out !== want.weight ||
                rsp_grad_change !== want.change || rsp_last_out !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected idx %0d w %h chg %h last %b, got %0d %h %h %b",
                           want.idx, want.weight, want.change, want.last,
                           rsp_elem_index_out, rsp_weight_out, rsp_grad_change,
                           rsp_last_out);
            end
         end
      end
   end

   // Cycle limit.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_MAX) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("adagrad_parameter_update verification failed");
            $finish;
         end
      end
   end

   // Test sequence.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = agu_pkg::KIND_LOAD;
      req_elem_index = '0;
      req_weight_in = '0;
      req_grad_value = '0;
      req_last_in = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      mismatch_count = 0;
      result_count = 0;
      update_count = 0;
      hold_off_cycles = 0;
      stall_random = 1'b0;
      model_step = agu_pkg::STEP_INIT;
      for (int i = 0; i < agu_pkg::VEC_LEN; i++) begin
         model_weight[i] = '0;
         model_sum[i] = agu_pkg::SUM_INIT;
         model_prev_grad[i] = '0;
         loaded[i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      stall_random = 1'b1;
      test_step_extremes();
      test_random(500, 32'd655);
      test_backpressure();
      test_random(450, 32'h0001_0000);
      test_random(250, 32'h0000_0001);
      repeat (20) @(posedge clock);
      $display("Covered %0d results, %0d of them gradient updates, over five learning rates,",
               result_count, update_count);
      $display("including saturation, sign extremes and a long result stall.");
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("adagrad_parameter_update verification clean");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count,
                  pending_results.size());
         $display("adagrad_parameter_update verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
